// ===== hdl/positional_array_list_macros.svh =====
// Assertion macros for the positional array list.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional_array_list: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional_array_list: next-cycle check failed");

`endif

// ===== hdl/pal_pkg.sv =====
// Shared constants and types for the positional array list.
// No dependencies; imported by every module of the block.
`default_nettype none
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 31;
  localparam int POS_W    = 7;
  localparam int OUT_CNT_W = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP    = 8;
  localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic load;
    logic shift_r;
    logic shift_l;
    logic cap;
    logic tap_sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 ok;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] cnt;
  } res_meta_t;

endpackage
`default_nettype wire

// ===== hdl/pal_cell.sv =====
// One storage cell of the list chain: holds a single entry and a read tap.
// Depends on pal_pkg for widths and the cell control struct.
`default_nettype none
module pal_cell
  import pal_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] new_val,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] entry,
  output logic [VAL_W-1:0] tap
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= new_val;
    end else if (ctrl.shift_r) begin
      entry <= left_val;
    end else if (ctrl.shift_l) begin
      entry <= right_val;
    end
  end

  // The tap carries the entry only in the cell that a read selects.
  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      tap <= ctrl.tap_sel ? entry : '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pal_read_tree.sv =====
// Two-stage registered OR tree that gathers the single live read tap.
// Depends on pal_pkg for widths and group sizing.
`default_nettype none
module pal_read_tree
  import pal_pkg::*;
(
  input  logic             clk,
  input  logic [VAL_W-1:0] taps [CAPACITY],
  output logic [VAL_W-1:0] result
);

  logic [VAL_W-1:0] grp [NGRP];
  logic [VAL_W-1:0] result_next;

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [VAL_W-1:0] grp_next;
    always_comb begin
      grp_next = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_next = grp_next | taps[g * GROUP + k];
        end
      end
    end
    always_ff @(posedge clk) begin
      grp[g] <= grp_next;
    end
  end

  always_comb begin
    result_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      result_next = result_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

// ===== hdl/positional_array_list.sv =====
// Top level of the positional array list: request decode, cell chain and result pipeline.
// Depends on pal_pkg, pal_cell, pal_read_tree and positional_array_list_macros.svh.
//
//  Channel   | Handshake           | Payload
//  ----------+---------------------+--------------------------------------------
//  request   | start, busy         | req_type, position, value
//  result    | done (strobe)       | ok, status, read_value, entry_count
//
// A request passes from its accepting edge to the edge that takes its result through the tap
// register in each cell, then the two register stages of the OR tree that gathers a read entry.
// Busy is high while the request is in the tap or first tree stage, so the next request can be
// accepted at the edge that takes the previous result. Inserts and deletes move the later entries
// by one cell at the accepting edge. Reset clears the fill count and the pipeline, not the entries.
// The receiver cannot stall: each result beat is shown for exactly one cycle with done high.
`default_nettype none
`include "positional_array_list_macros.svh"
module positional_array_list
  import pal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [POS_W-1:0]     position,
  input  logic [VAL_W-1:0]     value,
  output logic                 done,
  output logic                 ok,
  output logic [1:0]           status,
  output logic [VAL_W-1:0]     read_value,
  output logic [OUT_CNT_W-1:0] entry_count
);

  // Fill count and its update.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Pipeline valid bits and the result fields that ride alongside the read tree.
  logic      v1;
  logic      v2;
  res_meta_t p1;
  res_meta_t p2;
  res_meta_t p1_next;

  logic             acc;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             empty;
  logic             req_ok;
  logic [1:0]       req_status;
  logic             ins_ok;
  logic             del_ok;
  logic             rd_ok;

  logic [VAL_W-1:0] ent  [CAPACITY];
  logic [VAL_W-1:0] taps [CAPACITY];

  assign busy  = v1 | v2;
  assign acc   = start & ~busy;
  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // Request decode: the full or empty test takes precedence over the position test.
  always_comb begin
    req_ok     = 1'b0;
    req_status = ST_RANGE;
    unique case (req_type) inside
      REQ_INSERT: begin
        if (full) begin
          req_status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          req_status = ST_RANGE;
        end else begin
          req_ok     = 1'b1;
          req_status = ST_OK;
        end
      end
      REQ_DELETE, REQ_READ: begin
        if (empty) begin
          req_status = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          req_status = ST_RANGE;
        end else begin
          req_ok     = 1'b1;
          req_status = ST_OK;
        end
      end
      default: begin
        req_ok     = 1'b0;
        req_status = ST_RANGE;
      end
    endcase
  end

  assign ins_ok = acc & req_ok & (req_type == REQ_INSERT);
  assign del_ok = acc & req_ok & (req_type == REQ_DELETE);
  assign rd_ok  = acc & req_ok & (req_type == REQ_READ);

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // The reported count is the count after the request, truncated to the port width.
  always_comb begin
    p1_next.ok     = req_ok;
    p1_next.status = req_status;
    p1_next.cnt    = OUT_CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      v1    <= acc;
      v2    <= v1;
      done  <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1 <= p1_next;
    end
    p2          <= p1;
    ok          <= p2.ok;
    status      <= p2.status;
    entry_count <= p2.cnt;
  end

  // The cell chain. Each cell decides from its own index whether it loads the new value,
  // takes its left neighbour (insert) or its right neighbour (delete).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [CMP_W-1:0] idx;
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;

    assign idx = CMP_W'(i);

    always_comb begin
      ctrl.load    = ins_ok & (idx == pos_x);
      ctrl.shift_r = ins_ok & (idx > pos_x) & (idx <= cnt_x);
      ctrl.shift_l = del_ok & (idx >= pos_x) & (CMP_W'(i + 1) < cnt_x);
      ctrl.cap     = acc;
      ctrl.tap_sel = rd_ok & (idx == pos_x);
    end

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = ent[i - 1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = ent[i + 1];
    end

    pal_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_val   (value),
      .left_val  (left_val),
      .right_val (right_val),
      .entry     (ent[i]),
      .tap       (taps[i])
    );
  end

  pal_read_tree u_tree (
    .clk    (clk),
    .taps   (taps),
    .result (read_value)
  );

  // An accepted request always holds off the next one for the following cycle.
  `PAL_ASSERT_NXT(a_acc_busy, acc, busy)
  // A result beat only appears once the pipeline has drained.
  `PAL_ASSERT_IMP(a_done_idle, done, !busy)
  // Rejected requests never report an entry.
  `PAL_ASSERT_IMP(a_rej_zero, done && !ok, read_value == '0)
  // The fill count never exceeds the capacity.
  `PAL_ASSERT_IMP(a_cnt_cap, 1'b1, count <= CNT_W'(CAPACITY))

endmodule
`default_nettype wire

// ===== verif/positional_array_list_tb.sv =====
// Self-checking testbench for the positional array list: directed corner cases, then long
// random fill and drain phases, each result checked against a behavioural list model.
// Depends on pal_pkg and the positional_array_list RTL only.
`timescale 1ns / 100ps

module positional_array_list_tb
  import pal_pkg::*;
();

  // Request code 3 is not decoded by the block and must be rejected as out of range.
  localparam logic [1:0]       REQ_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MAX    = {VAL_W{1'b1}};
  localparam int               PHASE_LEN  = 200;
  localparam int               RAND_ITEMS = 1130;

  // One result beat as the block presents it.
  typedef struct packed {
    logic                 ok;
    logic [1:0]           status;
    logic [VAL_W-1:0]     read_value;
    logic [OUT_CNT_W-1:0] entry_count;
  } list_result_t;

  // Behavioural copy of the list.  Each accepted request is applied here at once, and the
  // result it must produce is queued until the block shows the matching result beat.
  class list_scoreboard;
    logic [VAL_W-1:0] slots [CAPACITY];
    int unsigned      fill;
    list_result_t     awaited [$];
    int unsigned      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      list_result_t want;
      int unsigned  p;
      int unsigned  i;
      want = '0;
      p    = pos;
      case (kind)
        REQ_INSERT: begin
          if (fill >= CAPACITY) begin
            want.status = ST_FULL;
          end else if (p > fill) begin
            want.status = ST_RANGE;
          end else begin
            for (i = fill; i > p; i--) slots[i] = slots[i-1];
            slots[p]    = val;
            fill++;
            want.ok     = 1'b1;
            want.status = ST_OK;
          end
        end
        REQ_DELETE: begin
          if (fill == 0) begin
            want.status = ST_EMPTY;
          end else if (p >= fill) begin
            want.status = ST_RANGE;
          end else begin
            for (i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            want.ok     = 1'b1;
            want.status = ST_OK;
          end
        end
        REQ_READ: begin
          if (fill == 0) begin
            want.status = ST_EMPTY;
          end else if (p >= fill) begin
            want.status = ST_RANGE;
          end else begin
            want.ok         = 1'b1;
            want.status     = ST_OK;
            want.read_value = slots[p];
          end
        end
        default: begin
          want.status = ST_RANGE;
        end
      endcase
      want.entry_count = OUT_CNT_W'(fill);
      awaited.push_back(want);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat ok=%0b status=%0d read_value=%0d count=%0d",
                 $time, got.ok, got.status, got.read_value, got.entry_count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.ok !== want.ok) begin
        $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, got.ok);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch, expected %0d, actual %0d",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                 $time, want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           req_type = REQ_INSERT;
  logic [POS_W-1:0]     position = '0;
  logic [VAL_W-1:0]     value = '0;
  logic                 done;
  logic                 ok;
  logic [1:0]           status;
  logic [VAL_W-1:0]     read_value;
  logic [OUT_CNT_W-1:0] entry_count;

  list_scoreboard sb;

  positional_array_list dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .position    (position),
    .value       (value),
    .done        (done),
    .ok          (ok),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops answering; the slowest correct run needs well under a
  // tenth of this.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // The result port cannot be held off, so every strobe is a beat taken at the edge that ends
  // its cycle.  Values are sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result('{ok, status, read_value, entry_count});
    end
  end

  // Sends one request beat.  An optional random pause comes first, with start low, so that
  // idle cycles land while the block is busy as well as while it waits.  The task returns at
  // the edge that accepts the beat, leaving start high; the next call either keeps it high
  // or lowers it, so start only ever gets one assignment per edge.
  task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (busy);
    sb.note_request(kind, pos, val);
  endtask

  initial begin
    int               n;
    int               roll;
    bit               filling;
    bit               may_idle;
    logic [1:0]       kind;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.  The list starts empty, so deletes and reads must report it empty,
    // and an insert anywhere but the front is out of range.
    send_request(REQ_READ,   7'd0,   '0,      1'b1);
    send_request(REQ_DELETE, 7'd0,   VAL_MAX, 1'b1);
    send_request(REQ_INSERT, 7'd1,   VAL_MAX, 1'b1);
    send_request(REQ_INSERT, 7'd127, '0,      1'b1);
    send_request(REQ_UNUSED, 7'd0,   '0,      1'b1);
    // Build a four-entry list by inserting at the front, at the end and in the middle.
    send_request(REQ_INSERT, 7'd0,   VAL_MAX, 1'b1);
    send_request(REQ_INSERT, 7'd0,   '0,      1'b1);
    send_request(REQ_INSERT, 7'd2,   31'h5555_5555, 1'b1);
    send_request(REQ_INSERT, 7'd1,   31'h2AAA_AAAA, 1'b1);
    for (n = 0; n < 4; n++) send_request(REQ_READ, POS_W'(n), VAL_MAX, 1'b0);
    // Positions at and beyond the count are out of range for reads and deletes.
    send_request(REQ_READ,   7'd4,   '0,      1'b1);
    send_request(REQ_READ,   7'd127, '0,      1'b1);
    send_request(REQ_DELETE, 7'd4,   '0,      1'b1);
    send_request(REQ_DELETE, 7'd127, '0,      1'b1);
    // Delete from the middle, the end and the front, reading back in between.
    send_request(REQ_DELETE, 7'd1,   '0,      1'b1);
    send_request(REQ_READ,   7'd1,   '0,      1'b1);
    send_request(REQ_DELETE, 7'd2,   '0,      1'b1);
    send_request(REQ_DELETE, 7'd0,   '0,      1'b1);
    send_request(REQ_READ,   7'd0,   '0,      1'b1);
    send_request(REQ_UNUSED, 7'd127, VAL_MAX, 1'b1);
    send_request(REQ_DELETE, 7'd0,   '0,      1'b1);
    send_request(REQ_READ,   7'd0,   '0,      1'b1);

    // Random part.  Phases alternate between a bias towards inserts, which drives the list
    // to full and keeps knocking on it, and a bias towards deletes, which drains it to empty.
    // Most positions are legal, with the ends favoured; the rest span the whole field.
    for (n = 0; n < RAND_ITEMS; n++) begin
      filling  = ((n / PHASE_LEN) % 2) == 0;
      may_idle = !(n >= 500 && n < 800);
      roll     = $urandom_range(0, 99);
      if (filling) begin
        kind = (roll < 60) ? REQ_INSERT : (roll < 75) ? REQ_DELETE :
               (roll < 95) ? REQ_READ : REQ_UNUSED;
      end else begin
        kind = (roll < 15) ? REQ_INSERT : (roll < 60) ? REQ_DELETE :
               (roll < 95) ? REQ_READ : REQ_UNUSED;
      end

      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        pos = POS_W'($urandom_range(0, 127));
      end else if (kind == REQ_INSERT) begin
        // Inserting at the count appends; anything up to it is legal.
        pos = (roll < 30) ? '0 : (roll < 45) ? POS_W'(sb.fill) :
              POS_W'($urandom_range(0, sb.fill));
      end else if (sb.fill == 0) begin
        pos = '0;
      end else begin
        pos = (roll < 30) ? '0 : (roll < 45) ? POS_W'(sb.fill - 1) :
              POS_W'($urandom_range(0, sb.fill - 1));
      end

      roll = $urandom_range(0, 9);
      val  = (roll == 0) ? '0 : (roll == 1) ? VAL_MAX : VAL_W'($urandom());

      send_request(kind, pos, val, may_idle);
    end
    start <= 1'b0;

    // Let the last results come back, then a few more cycles to catch any stray beat.
    for (n = 0; n < 200 && sb.awaited.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.awaited.size());
      sb.errors += sb.awaited.size();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== positional_array_list.f =====
+incdir+hdl
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/pal_read_tree.sv
hdl/positional_array_list.sv
verif/positional_array_list_tb.sv
